// File: rtl/core/aeu_pkg.sv
// Shared constants and types of the accumulator execute unit.
package aeu_pkg;

  localparam int unsigned MemWordsDefault = 1024;
  localparam int unsigned DataW = 32;

  localparam logic [4:0] ActLoad    = 5'd0;
  localparam logic [4:0] ActAdd     = 5'd1;
  localparam logic [4:0] ActSub     = 5'd2;
  localparam logic [4:0] ActXor     = 5'd3;
  localparam logic [4:0] ActMul     = 5'd4;
  localparam logic [4:0] ActPrint   = 5'd5;
  localparam logic [4:0] ActClear   = 5'd6;
  localparam logic [4:0] ActSetSwap = 5'd7;
  localparam logic [4:0] ActNeg     = 5'd8;
  localparam logic [4:0] ActNot     = 5'd9;
  localparam logic [4:0] ActX2Y     = 5'd10;
  localparam logic [4:0] ActY2X     = 5'd11;
  localparam logic [4:0] ActSkipNe  = 5'd12;
  localparam logic [4:0] ActSkipGe  = 5'd13;
  localparam logic [4:0] ActMod     = 5'd14;
  localparam logic [4:0] ActDiv     = 5'd15;
  localparam logic [4:0] ActSquare  = 5'd16;
  localparam logic [4:0] ActSqrt    = 5'd17;
  localparam logic [4:0] ActStore   = 5'd18;
  localparam logic [4:0] ActLoadMem = 5'd19;
  localparam logic [4:0] ActCharOut = 5'd20;
  localparam logic [4:0] ActCharIn  = 5'd21;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StZeroDiv = 3'd1;
  localparam logic [2:0] StNegRoot = 3'd2;
  localparam logic [2:0] StBadAddr = 3'd3;
  localparam logic [2:0] StBadAct  = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic       load_op;    // capture transaction fields
    logic       clr_step;   // memory clearing write
    logic       simple;     // simple actions and error finish
    logic       mul_start;  // register multiplier product
    logic       div_init;
    logic       div_step;
    logic       div_fin;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       sqrt_fin;
    logic       mem_wr;
    logic       mem_rd;     // read data now valid, load acc
    logic       mul_fin;
    logic [2:0] err;
  } aeu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [4:0] action;
    logic       div_zero;
    logic       acc_neg;
    logic       addr_bad;
  } aeu_sts_t;

endpackage

// File: rtl/core/aeu_ram.sv
// Generic single-port RAM with registered read.
module aeu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: rtl/core/aeu_datapath.sv
// Datapath: registers, multiplier, serial divider and root unit, data memory.
module aeu_datapath #(
  parameter int unsigned MemWords = aeu_pkg::MemWordsDefault
) (
  input  logic                   clk,
  input  logic [4:0]             action,
  input  logic [31:0]            immediate,
  input  logic [8:0]             char_in,
  input  logic [$clog2(MemWords):0] clr_addr,
  input  aeu_pkg::aeu_cmd_t      cmd,
  input  logic                   rst,
  output aeu_pkg::aeu_sts_t      sts,
  output logic [31:0]            acc_value,
  output logic [2:0]             status,
  output logic                   skip_next,
  output logic                   emit_number,
  output logic                   emit_char,
  output logic [7:0]             char_byte
);
  import aeu_pkg::*;

  localparam int unsigned AW = $clog2(MemWords);

  logic [4:0]  act;
  logic [31:0] imm;
  logic [8:0]  chr;
  logic [31:0] acc, yreg;
  logic [31:0] prod;

  // divider state
  logic [31:0] dq, drem, dvs;
  logic        dneg_q, dneg_r;
  // root state
  logic [31:0] rv, rres, rbit;

  logic [31:0] mem_rdata;
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0] mem_wdata;

  assign acc_value = acc;

  always_comb begin
    sts.action   = act;
    sts.div_zero = (imm == '0);
    sts.acc_neg  = acc[31];
    sts.addr_bad = imm[31] || (imm >= 32'(MemWords));
  end

  // divider step: restoring, one quotient bit per cycle
  logic [32:0] dtrial;
  logic [31:0] drem_sh;
  assign drem_sh = {drem[30:0], dq[31]};
  assign dtrial  = {1'b0, drem_sh} - {1'b0, dvs};

  logic [31:0] rsum;
  assign rsum = rres + rbit;

  assign mem_we    = cmd.clr_step || cmd.mem_wr;
  assign mem_addr  = cmd.clr_step ? clr_addr[AW-1:0] : imm[AW-1:0];
  assign mem_wdata = cmd.clr_step ? '0 : acc;

  aeu_ram #(.Width(DataW), .Depth(MemWords)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      act <= action;
      imm <= immediate;
      chr <= char_in;
    end
    if (cmd.mul_start) prod <= acc * ((act == ActSquare) ? acc : imm);

    if (cmd.div_init) begin
      dq     <= acc[31] ? (32'd0 - acc) : acc;
      dvs    <= imm[31] ? (32'd0 - imm) : imm;
      drem   <= '0;
      dneg_q <= acc[31] ^ imm[31];
      dneg_r <= acc[31];
    end else if (cmd.div_step) begin
      if (!dtrial[32]) begin
        drem <= dtrial[31:0];
        dq   <= {dq[30:0], 1'b1};
      end else begin
        drem <= drem_sh;
        dq   <= {dq[30:0], 1'b0};
      end
    end

    if (cmd.sqrt_init) begin
      rv   <= acc;
      rres <= '0;
      rbit <= 32'h4000_0000;
    end else if (cmd.sqrt_step) begin
      if (rv >= rsum) begin
        rv   <= rv - rsum;
        rres <= (rres >> 1) + rbit;
      end else begin
        rres <= rres >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      yreg        <= '0;
      status      <= StOk;
      skip_next   <= 1'b0;
      emit_number <= 1'b0;
      emit_char   <= 1'b0;
      char_byte   <= '0;
    end else begin
      if (cmd.simple || cmd.div_fin || cmd.sqrt_fin || cmd.mem_rd || cmd.mul_fin ||
          cmd.mem_wr) begin
        status      <= cmd.err;
        skip_next   <= 1'b0;
        emit_number <= 1'b0;
        emit_char   <= 1'b0;
        char_byte   <= '0;
      end
      if (cmd.simple && cmd.err == StOk) begin
        case (act)
          ActLoad:    acc <= imm;
          ActAdd:     acc <= acc + imm;
          ActSub:     acc <= acc - imm;
          ActXor:     acc <= acc ^ imm;
          ActPrint:   emit_number <= 1'b1;
          ActClear:   acc <= '0;
          ActSetSwap: begin
            yreg <= acc;
            acc  <= imm;
          end
          ActNeg:     acc <= 32'd0 - acc;
          ActNot:     acc <= ~acc;
          ActX2Y:     yreg <= acc;
          ActY2X:     acc <= yreg;
          ActSkipNe:  skip_next <= (acc != imm);
          ActSkipGe:  skip_next <= ($signed(acc) >= $signed(imm));
          ActCharOut: begin
            emit_char <= 1'b1;
            char_byte <= acc[7:0];
          end
          ActCharIn:  acc <= {{23{chr[8]}}, chr};
          default:    acc <= acc;
        endcase
      end
      if (cmd.mul_fin) acc <= prod;
      if (cmd.div_fin) begin
        if (act == ActMod) acc <= dneg_r ? (32'd0 - drem) : drem;
        else               acc <= dneg_q ? (32'd0 - dq) : dq;
      end
      if (cmd.sqrt_fin) acc <= rres;
      if (cmd.mem_rd)   acc <= mem_rdata;
    end
  end
endmodule

// File: rtl/core/aeu_ctrl.sv
// Controller: sequences memory clearing and the multi-cycle actions.
module aeu_ctrl #(
  parameter int unsigned MemWords = aeu_pkg::MemWordsDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_fire,
  input  logic                      out_fire,
  input  aeu_pkg::aeu_sts_t         sts,
  output aeu_pkg::aeu_cmd_t         cmd,
  output logic [$clog2(MemWords):0] clr_addr,
  output logic                      in_rdy,
  output logic                      out_vld
);
  import aeu_pkg::*;

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SDec   = 3'd2;
  localparam logic [2:0] SDiv   = 3'd3;
  localparam logic [2:0] SSqrt  = 3'd4;
  localparam logic [2:0] SWait  = 3'd5;
  localparam logic [2:0] SOut   = 3'd6;

  logic [2:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic [$clog2(MemWords):0] clr_next;

  assign in_rdy  = (state == SIdle);
  assign out_vld = (state == SOut);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    clr_next   = clr_addr;
    cmd.load_op = in_fire;
    case (state)
      SClear: begin
        cmd.clr_step = 1'b1;
        clr_next = clr_addr + 1'b1;
        if (clr_addr == ($clog2(MemWords)+1)'(MemWords - 1)) state_next = SIdle;
      end
      SIdle: if (in_fire) state_next = SDec;
      SDec: begin
        cnt_next = '0;
        if (sts.action > ActCharIn) begin
          cmd.err = StBadAct; cmd.simple = 1'b1; state_next = SOut;
        end else if (sts.action inside {ActMod, ActDiv}) begin
          if (sts.div_zero) begin
            cmd.err = StZeroDiv; cmd.simple = 1'b1; state_next = SOut;
          end else begin
            cmd.div_init = 1'b1; state_next = SDiv;
          end
        end else if (sts.action == ActSqrt) begin
          if (sts.acc_neg) begin
            cmd.err = StNegRoot; cmd.simple = 1'b1; state_next = SOut;
          end else begin
            cmd.sqrt_init = 1'b1; state_next = SSqrt;
          end
        end else if (sts.action inside {ActStore, ActLoadMem}) begin
          if (sts.addr_bad) begin
            cmd.err = StBadAddr; cmd.simple = 1'b1; state_next = SOut;
          end else if (sts.action == ActStore) begin
            cmd.mem_wr = 1'b1; state_next = SOut;
          end else begin
            state_next = SWait;
          end
        end else if (sts.action inside {ActMul, ActSquare}) begin
          cmd.mul_start = 1'b1; state_next = SWait;
        end else begin
          cmd.simple = 1'b1; state_next = SOut;
        end
      end
      SDiv: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == 6'd31) begin
          cnt_next = '0; state_next = SWait;
        end
      end
      SSqrt: begin
        cmd.sqrt_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == 6'd15) state_next = SWait;
      end
      SWait: begin
        state_next = SOut;
        if (sts.action inside {ActMod, ActDiv}) cmd.div_fin = 1'b1;
        else if (sts.action == ActSqrt) cmd.sqrt_fin = 1'b1;
        else if (sts.action == ActLoadMem) cmd.mem_rd = 1'b1;
        else cmd.mul_fin = 1'b1;
      end
      SOut: if (out_fire) state_next = SIdle;
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= SClear;
      cnt      <= '0;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      clr_addr <= clr_next;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_fire |=> out_vld) else $error("result dropped");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    !in_rdy |-> !in_fire) else $error("accept while busy");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |=> state == SDiv) else $error("divider not started");
endmodule

// File: rtl/core/accumulator_execute_unit.sv
// Top level of the accumulator execute unit.
//  channel | dir | fields
//  s_axis  | in  | tdata: action[4:0], immediate[36:5], char_in[45:37]
//  m_axis  | out | tdata: acc_value[31:0], status[34:32], skip_next[35],
//          |     |        emit_number[36], emit_char[37], char_byte[45:38]
// Simple actions go from decode straight to output; mul/square and load_mem pass a wait
// state; div/mod first run a 32-step serial divider, sqrt a 16-step root unit.
// After reset the data memory is cleared one word a cycle, all MEM_WORDS words,
// with s_axis_tready low. A result waits in the output register until taken.
module accumulator_execute_unit #(
  parameter int unsigned MEM_WORDS = aeu_pkg::MemWordsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // action, immediate, char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // acc_value, status, skip, emit_n, emit_c, char_byte
);
  import aeu_pkg::*;

  aeu_cmd_t cmd;
  aeu_sts_t sts;
  logic [$clog2(MEM_WORDS):0] clr_addr;
  logic in_fire, out_fire;
  logic [31:0] acc_value;
  logic [2:0]  status;
  logic        skip_next, emit_number, emit_char;
  logic [7:0]  char_byte;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata = {2'b00, char_byte, emit_char, emit_number, skip_next, status,
                         acc_value};

  aeu_ctrl #(.MemWords(MEM_WORDS)) u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire), .sts(sts),
    .cmd(cmd), .clr_addr(clr_addr), .in_rdy(s_axis_tready), .out_vld(m_axis_tvalid)
  );

  aeu_datapath #(.MemWords(MEM_WORDS)) u_dp (
    .clk(clk), .action(s_axis_tdata[4:0]), .immediate(s_axis_tdata[36:5]),
    .char_in(s_axis_tdata[45:37]), .clr_addr(clr_addr), .cmd(cmd), .rst(rst),
    .sts(sts), .acc_value(acc_value), .status(status), .skip_next(skip_next),
    .emit_number(emit_number), .emit_char(emit_char), .char_byte(char_byte)
  );
endmodule
